>>> rtl/daubechies4_wavelet_step_assert.svh
// Assertion helpers for the RTL of the wavelet step, included by d4ws_back.
`ifndef DAUBECHIES4_WAVELET_STEP_ASSERT_SVH
`define DAUBECHIES4_WAVELET_STEP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define D4WS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define D4WS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/d4ws_pkg.sv
package d4ws_pkg;

  localparam int MAX_LEN       = 64;
  localparam int SAMPLE_BITS   = 16;
  localparam int COEF_BITS     = 17;
  localparam int LEN_BITS      = 7;
  localparam int POS_BITS      = $clog2(MAX_LEN);
  localparam int MEM_ADDR_BITS = POS_BITS + 1;
  localparam int TAP_BITS      = 16;
  localparam int ACC_BITS      = 32;
  localparam int FRAC_BITS     = 15;
  localparam int IN_DATA_BITS  = 16;
  localparam int OUT_DATA_BITS = 24;

  localparam logic signed [TAP_BITS-1:0] H0 = 16'sd15826;
  localparam logic signed [TAP_BITS-1:0] H1 = 16'sd27411;
  localparam logic signed [TAP_BITS-1:0] H2 = 16'sd7345;
  localparam logic signed [TAP_BITS-1:0] H3 = -16'sd4240;

  localparam logic signed [ACC_BITS-1:0] ROUND_BIAS = 32'sd16384;

  typedef enum logic [1:0] {
    K_FWD_SMOOTH,
    K_FWD_DETAIL,
    K_INV_EVEN,
    K_INV_ODD
  } kind_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } seq_state_t;

  typedef enum logic {
    REG_FORWARD_MODE = 1'b0,
    REG_FRAME_LENGTH = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic                bank;
    logic [LEN_BITS-1:0] len;
    logic                fwd;
  } job_t;

  typedef struct packed {
    logic                           en;
    logic [MEM_ADDR_BITS-1:0]       addr;
    logic signed [SAMPLE_BITS-1:0]  data;
  } wr_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

  typedef struct packed {
    logic                valid;
    kind_t               kind;
    logic                phase;
    logic [POS_BITS-1:0] pos;
    logic                last;
    logic                bank;
  } ctl_t;

  // Even length clamped into 4 .. MAX_LEN.
  function automatic logic [LEN_BITS-1:0] eff_len(input logic [LEN_BITS-1:0] fl);
    logic [LEN_BITS-1:0] n;
    n = {fl[LEN_BITS-1:1], 1'b0};
    if (n < LEN_BITS'(4)) begin
      n = LEN_BITS'(4);
    end else if (n > LEN_BITS'(MAX_LEN)) begin
      n = LEN_BITS'(MAX_LEN);
    end
    return n;
  endfunction

  // Filter tap for one of the four samples that feed a result.
  function automatic logic signed [TAP_BITS-1:0] coef(input kind_t k, input logic [1:0] tap);
    logic signed [TAP_BITS-1:0] c;
    c = H0;
    unique case (k)
      K_FWD_SMOOTH: begin
        case (tap)
          2'd0:    c = H0;
          2'd1:    c = H1;
          2'd2:    c = H2;
          default: c = H3;
        endcase
      end
      K_FWD_DETAIL: begin
        case (tap)
          2'd0:    c = H3;
          2'd1:    c = -H2;
          2'd2:    c = H1;
          default: c = -H0;
        endcase
      end
      K_INV_EVEN: begin
        case (tap)
          2'd0:    c = H2;
          2'd1:    c = H1;
          2'd2:    c = H0;
          default: c = H3;
        endcase
      end
      K_INV_ODD: begin
        case (tap)
          2'd0:    c = H3;
          2'd1:    c = -H0;
          2'd2:    c = H1;
          default: c = -H2;
        endcase
      end
      default: c = H0;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/d4ws_front.sv
module d4ws_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [d4ws_pkg::IN_DATA_BITS-1:0]    in_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic                                 cfg_index,
  input  logic [d4ws_pkg::LEN_BITS-1:0]        cfg_data,
  input  logic                                 q_full,
  output logic                                 q_push,
  output d4ws_pkg::job_t                       q_job,
  input  d4ws_pkg::release_t                   rel,
  output d4ws_pkg::wr_t                        wr
);

  logic                            fwd_r;
  logic [d4ws_pkg::LEN_BITS-1:0]   flen_r;
  logic [d4ws_pkg::LEN_BITS-1:0]   fill_r, fill_nxt;
  logic                            wbank_r, wbank_nxt;
  logic [1:0]                      busy_r, busy_nxt;
  logic [d4ws_pkg::LEN_BITS-1:0]   n_eff;
  logic [d4ws_pkg::LEN_BITS-1:0]   fill_inc;
  logic                            take;
  logic                            frame_done;

  assign cfg_ready  = 1'b1;
  assign in_tready  = !busy_r[wbank_r] && !q_full;
  assign take       = in_tvalid && in_tready;
  assign n_eff      = d4ws_pkg::eff_len(flen_r);
  assign fill_inc   = fill_r + d4ws_pkg::LEN_BITS'(1);
  // A shortened length mid-frame still ends the frame on this sample.
  assign frame_done = fill_inc >= n_eff;

  assign wr.en   = take;
  assign wr.addr = {wbank_r, fill_r[d4ws_pkg::POS_BITS-1:0]};
  assign wr.data = in_tdata[d4ws_pkg::SAMPLE_BITS-1:0];

  assign q_push    = take && frame_done;
  assign q_job.bank = wbank_r;
  assign q_job.len  = n_eff;
  assign q_job.fwd  = fwd_r;

  always_comb begin
    fill_nxt  = fill_r;
    wbank_nxt = wbank_r;
    busy_nxt  = busy_r;
    if (rel.valid) begin
      busy_nxt[rel.bank] = 1'b0;
    end
    if (take) begin
      if (frame_done) begin
        fill_nxt          = '0;
        wbank_nxt         = !wbank_r;
        busy_nxt[wbank_r] = 1'b1;
      end else begin
        fill_nxt = fill_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      wbank_r <= 1'b0;
      busy_r  <= '0;
    end else begin
      fill_r  <= fill_nxt;
      wbank_r <= wbank_nxt;
      busy_r  <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r  <= 1'b1;
      flen_r <= d4ws_pkg::LEN_BITS'(d4ws_pkg::MAX_LEN);
    end else if (cfg_valid) begin
      unique case (d4ws_pkg::reg_index_t'(cfg_index))
        d4ws_pkg::REG_FORWARD_MODE: fwd_r  <= cfg_data[0];
        d4ws_pkg::REG_FRAME_LENGTH: flen_r <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/d4ws_fifo.sv
module d4ws_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  d4ws_pkg::job_t din,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output d4ws_pkg::job_t dout
);

  d4ws_pkg::job_t entry_r [2];
  logic           wptr_r, rptr_r;
  logic [1:0]     cnt_r;

  assign full  = cnt_r == 2'd2;
  assign valid = cnt_r != 2'd0;
  assign dout  = entry_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) begin
        wptr_r <= !wptr_r;
      end
      if (pop) begin
        rptr_r <= !rptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

>>> rtl/d4ws_back.sv
`include "daubechies4_wavelet_step_assert.svh"

module d4ws_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 q_valid,
  input  d4ws_pkg::job_t                       q_job,
  output logic                                 q_pop,
  input  d4ws_pkg::wr_t                        wr,
  output d4ws_pkg::release_t                   rel,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [d4ws_pkg::OUT_DATA_BITS-1:0]   out_tdata,
  output logic                                 out_tlast
);

  localparam int LB = d4ws_pkg::LEN_BITS;
  localparam int PB = d4ws_pkg::POS_BITS;

  // Frame buffer: two banks, one loading while the other is read.
  logic signed [d4ws_pkg::SAMPLE_BITS-1:0] mem [2**d4ws_pkg::MEM_ADDR_BITS];

  d4ws_pkg::seq_state_t state_r, state_nxt;
  logic                 cur_bank_r;
  logic [LB-1:0]        cur_n_r;
  logic                 cur_fwd_r;
  logic [PB-1:0]        pos_r;
  logic                 phase_r;

  logic                 en;
  logic                 issue;
  logic                 last_pos;

  logic [LB-1:0]        pos7, nh, fk, fm, fm1, fa, fb, ik, ip, ia, ib;
  logic                 upper;
  d4ws_pkg::kind_t      kind;
  logic [PB-1:0]        addr_a, addr_b;

  d4ws_pkg::ctl_t       s0_r, s1_r, s2_r, s3_r;
  logic [d4ws_pkg::MEM_ADDR_BITS-1:0] s0_addr_a_r, s0_addr_b_r;
  logic signed [d4ws_pkg::SAMPLE_BITS-1:0] rd_a_r, rd_b_r;
  logic signed [d4ws_pkg::TAP_BITS-1:0]    coef_a, coef_b;
  logic signed [d4ws_pkg::ACC_BITS-1:0]    prod_a_nxt, prod_b_nxt, prod_a_r, prod_b_r;
  logic signed [d4ws_pkg::ACC_BITS-1:0]    sum_r, acc_r, total;

  logic                                    out_valid_r;
  logic signed [d4ws_pkg::COEF_BITS-1:0]   out_coef_r;
  logic [PB-1:0]                           out_pos_r;
  logic                                    out_last_r;
  logic                                    out_bank_r;

  // The whole read pipeline freezes while a result waits at the output.
  assign en       = !out_valid_r || out_tready;
  assign last_pos = ({1'b0, pos_r} + LB'(1)) == cur_n_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      d4ws_pkg::ST_IDLE: begin
        if (q_valid && en) begin
          state_nxt = d4ws_pkg::ST_RUN;
        end
      end
      d4ws_pkg::ST_RUN: begin
        if (en && phase_r && last_pos) begin
          state_nxt = d4ws_pkg::ST_IDLE;
        end
      end
      default: state_nxt = d4ws_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    issue = 1'b0;
    unique case (state_r)
      d4ws_pkg::ST_IDLE: q_pop = q_valid && en;
      d4ws_pkg::ST_RUN:  issue = en;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= d4ws_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      phase_r <= 1'b0;
    end else if (q_pop) begin
      pos_r   <= '0;
      phase_r <= 1'b0;
    end else if (issue) begin
      phase_r <= !phase_r;
      if (phase_r) begin
        pos_r <= pos_r + PB'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_bank_r <= q_job.bank;
      cur_n_r    <= q_job.len;
      cur_fwd_r  <= q_job.fwd;
    end
  end

  // Tap addresses. Forward results read four neighbors starting at an even
  // sample, wrapping at the frame end; inverse results read the previous and
  // current smooth/detail pairs, two taps per phase.
  always_comb begin
    pos7  = {1'b0, pos_r};
    nh    = cur_n_r >> 1;
    upper = pos7 >= nh;
    fk    = upper ? pos7 - nh : pos7;
    fm    = {fk[LB-2:0], 1'b0} + {{(LB-2){1'b0}}, phase_r, 1'b0};
    fm1   = fm + LB'(1);
    fa    = (fm >= cur_n_r) ? fm - cur_n_r : fm;
    fb    = (fm1 >= cur_n_r) ? fm1 - cur_n_r : fm1;
    ik    = pos7 >> 1;
    ip    = (ik == '0) ? nh - LB'(1) : ik - LB'(1);
    ia    = phase_r ? ik : ip;
    ib    = ia + nh;
    if (cur_fwd_r) begin
      addr_a = fa[PB-1:0];
      addr_b = fb[PB-1:0];
      kind   = upper ? d4ws_pkg::K_FWD_DETAIL : d4ws_pkg::K_FWD_SMOOTH;
    end else begin
      addr_a = ia[PB-1:0];
      addr_b = ib[PB-1:0];
      kind   = pos_r[0] ? d4ws_pkg::K_INV_ODD : d4ws_pkg::K_INV_EVEN;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  assign coef_a     = d4ws_pkg::coef(s1_r.kind, {s1_r.phase, 1'b0});
  assign coef_b     = d4ws_pkg::coef(s1_r.kind, {s1_r.phase, 1'b1});
  assign prod_a_nxt = d4ws_pkg::ACC_BITS'(rd_a_r) * d4ws_pkg::ACC_BITS'(coef_a);
  assign prod_b_nxt = d4ws_pkg::ACC_BITS'(rd_b_r) * d4ws_pkg::ACC_BITS'(coef_b);
  assign total      = acc_r + sum_r + d4ws_pkg::ROUND_BIAS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_r        <= '0;
      s1_r        <= '0;
      s2_r        <= '0;
      s3_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s0_r.valid  <= issue;
      s0_r.kind   <= kind;
      s0_r.phase  <= phase_r;
      s0_r.pos    <= pos_r;
      s0_r.last   <= last_pos;
      s0_r.bank   <= cur_bank_r;
      s1_r        <= s0_r;
      s2_r        <= s1_r;
      s3_r        <= s2_r;
      out_valid_r <= s3_r.valid && s3_r.phase;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_addr_a_r <= {cur_bank_r, addr_a};
      s0_addr_b_r <= {cur_bank_r, addr_b};
      rd_a_r      <= mem[s0_addr_a_r];
      rd_b_r      <= mem[s0_addr_b_r];
      prod_a_r    <= prod_a_nxt;
      prod_b_r    <= prod_b_nxt;
      sum_r       <= prod_a_r + prod_b_r;
      if (s3_r.valid && !s3_r.phase) begin
        acc_r <= sum_r;
      end
      if (s3_r.valid && s3_r.phase) begin
        out_coef_r <= total[d4ws_pkg::ACC_BITS-1:d4ws_pkg::FRAC_BITS];
        out_pos_r  <= s3_r.pos;
        out_last_r <= s3_r.last;
        out_bank_r <= s3_r.bank;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {1'b0, out_pos_r, out_coef_r};

  // The bank goes back to the loader once its final result has left.
  assign rel.valid = out_valid_r && out_tready && out_last_r;
  assign rel.bank  = out_bank_r;

  `D4WS_ASSERT_NOW(a_pos_in_frame, state_r == d4ws_pkg::ST_RUN, ({1'b0, pos_r} < cur_n_r), "position beyond frame length")
  `D4WS_ASSERT_NEXT(a_phase_pair, en && s0_r.valid && !s0_r.phase, s0_r.valid && s0_r.phase, "first tap pair not followed by second")
  `D4WS_ASSERT_NEXT(a_job_start, q_pop, state_r == d4ws_pkg::ST_RUN && pos_r == '0 && !phase_r, "job did not start at position zero")

endmodule

>>> rtl/daubechies4_wavelet_step.sv
// One level of the D4 wavelet transform with circular wraparound, forward
// or inverse. Samples are taken one per cycle into one bank of a two-bank
// frame buffer; the sample that completes a frame (frame_length, even,
// clamped to 4..64, taken when that sample arrives) hands the bank to the
// result engine, and loading of the next frame continues in the other bank.
// Each result needs four buffer reads and the buffer has two read ports, so
// it is read as two tap pairs in turn; reads for later results overlap in
// the pipeline, which freezes while a result waits at the output. A completed
// frame passes the job queue and idle state, then its reads go through s0..s3.
// Input stalls only when both banks hold frames whose results have not all
// been delivered. Buffer entries need no clearing after reset.
module daubechies4_wavelet_step (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [d4ws_pkg::IN_DATA_BITS-1:0]    in_tdata,   // [15:0] sample
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [d4ws_pkg::OUT_DATA_BITS-1:0]   out_tdata,  // [16:0] coefficient, [22:17] position
  output logic                                 out_tlast,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic                                 cfg_index,
  input  logic [d4ws_pkg::LEN_BITS-1:0]        cfg_data
);

  logic               q_full;
  logic               q_push;
  logic               q_pop;
  logic               q_valid;
  d4ws_pkg::job_t     q_job_in;
  d4ws_pkg::job_t     q_job_out;
  d4ws_pkg::release_t rel;
  d4ws_pkg::wr_t      wr;

  d4ws_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (q_job_in),
    .rel       (rel),
    .wr        (wr)
  );

  d4ws_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_job_in),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (q_job_out)
  );

  d4ws_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_job      (q_job_out),
    .q_pop      (q_pop),
    .wr         (wr),
    .rel        (rel),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
